// File: rtl/fpa_pkg.sv
package fpa_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int WORD_WIDTH_DEF = 32;
    localparam int OP_W           = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_FROMINT = 4'd14,
        OP_TOINT   = 4'd15
    } t_op;

    typedef struct packed {
        t_op                                operation;
        logic signed [WORD_WIDTH_DEF-1:0]   operand_a;
        logic signed [WORD_WIDTH_DEF-1:0]   operand_b;
    } t_in;

    typedef struct packed {
        logic signed [WORD_WIDTH_DEF-1:0]   result;
        logic                               flag;
        logic                               divide_by_zero;
    } t_out;

endpackage

// File: rtl/fpa_mul.sv
module fpa_mul
    import fpa_pkg::*;
#(
    parameter int WW = WORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic [WW-1:0] i_a,
    input  logic [WW-1:0] i_b,
    output logic [WW-1:0] o_q
);
    // Three stages: magnitudes, unsigned product, scale and sign.
    logic [WW-1:0]   r_ma, r_mb;
    logic            r_neg1, r_neg2;
    logic [2*WW-1:0] r_prod;
    logic [2*WW-1:0] n_sh;

    always_ff @(posedge i_clk) begin
        r_ma   <= i_a[WW-1] ? (~i_a + 1'b1) : i_a;
        r_mb   <= i_b[WW-1] ? (~i_b + 1'b1) : i_b;
        r_neg1 <= i_a[WW-1] ^ i_b[WW-1];
        r_prod <= {{WW{1'b0}}, r_ma} * {{WW{1'b0}}, r_mb};
        r_neg2 <= r_neg1;
    end

    assign n_sh = r_prod >> FB;
    assign o_q  = r_neg2 ? (~n_sh[WW-1:0] + 1'b1) : n_sh[WW-1:0];
endmodule

// File: rtl/fpa_div.sv
module fpa_div
    import fpa_pkg::*;
#(
    parameter int WW = WORD_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic [WW-1:0] i_a,
    input  logic [WW-1:0] i_b,
    output logic [WW-1:0] o_q
);
    // Restoring division, one quotient bit per stage. Dividend is |a| << FB.
    localparam int NW = WW + FB;

    logic [NW-1:0] r_num [NW+1];
    logic [WW-1:0] r_d   [NW+1];
    logic [NW-1:0] r_q   [NW+1];
    logic [WW:0]   r_rem [NW+1];
    logic          r_neg [NW+1];

    always_ff @(posedge i_clk) begin
        r_num[0] <= {(i_a[WW-1] ? (~i_a + 1'b1) : i_a), {FB{1'b0}}};
        r_d[0]   <= i_b[WW-1] ? (~i_b + 1'b1) : i_b;
        r_q[0]   <= '0;
        r_rem[0] <= '0;
        r_neg[0] <= i_a[WW-1] ^ i_b[WW-1];
    end

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [WW+1:0] n_t;
        logic          n_ge;
        assign n_t  = {r_rem[s], r_num[s][NW-1]};
        assign n_ge = n_t >= {2'b00, r_d[s]};
        always_ff @(posedge i_clk) begin
            r_num[s+1] <= {r_num[s][NW-2:0], 1'b0};
            r_d[s+1]   <= r_d[s];
            r_neg[s+1] <= r_neg[s];
            r_q[s+1]   <= {r_q[s][NW-2:0], n_ge};
            r_rem[s+1] <= n_ge ? (WW+1)'(n_t - {2'b00, r_d[s]}) : n_t[WW:0];
        end
    end

    assign o_q = r_neg[NW] ? (~r_q[NW][WW-1:0] + 1'b1) : r_q[NW][WW-1:0];
endmodule

// File: rtl/fixed_point_alu.sv
// Fixed-point ALU, one beat accepted every cycle; busy is always low.
// Every operation has the same latency, set by the bit-per-stage divider; the short
// operations are delayed to match.
// Throughput is one beat per cycle. The receiver cannot stall.
// Synchronous active-low reset clears the valid pipeline only.
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_item
);
    // The word width follows the payload structs in the package.
    localparam int WW  = WORD_WIDTH_DEF;
    localparam int LAT = WW + FRAC_BITS + 1;

    logic          n_acc;
    logic [WW-1:0] mul_q, div_q;

    assign busy  = 1'b0;
    assign n_acc = start;

    fpa_mul #(.WW(WW), .FB(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_a(i_item.operand_a), .i_b(i_item.operand_b), .o_q(mul_q));
    fpa_div #(.WW(WW), .FB(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_a(i_item.operand_a), .i_b(i_item.operand_b), .o_q(div_q));

    // The simple operations finish in one stage and then ride a delay line.
    t_op           n_op;
    logic signed [WW-1:0] a, b;
    logic [WW-1:0] n_res;
    logic          n_flag, n_dz, lt_ab, lt_ba;

    always_comb begin
        n_op   = i_item.operation;
        a      = i_item.operand_a;
        b      = i_item.operand_b;
        lt_ab  = a < b;
        lt_ba  = b < a;
        n_res  = '0;
        n_flag = 1'b0;
        n_dz   = 1'b0;
        case (n_op)
            OP_ADD:     n_res = a + b;
            OP_SUB:     n_res = a - b;
            OP_DIV:     n_dz  = (b == '0);
            OP_GT:      n_flag = lt_ba;
            OP_LT:      n_flag = lt_ab;
            OP_GE:      n_flag = !lt_ab;
            OP_LE:      n_flag = !lt_ba;
            OP_EQ:      n_flag = (a == b);
            OP_NE:      n_flag = (a != b);
            OP_MIN:     n_res = lt_ab ? a : b;
            OP_MAX:     n_res = lt_ba ? a : b;
            OP_INC:     n_res = a + 1'b1;
            OP_DEC:     n_res = a - 1'b1;
            OP_FROMINT: n_res = a <<< FRAC_BITS;
            OP_TOINT:   n_res = a >>> FRAC_BITS;
            default:    n_res = '0;
        endcase
    end

    logic          r_v   [LAT];
    t_op           r_op  [LAT];
    logic [WW-1:0] r_res [LAT];
    logic          r_fl  [LAT];
    logic          r_dz  [LAT];

    always_ff @(posedge i_clk) begin
        r_v[0]   <= i_rst_n & n_acc;
        r_op[0]  <= n_op;
        r_res[0] <= n_res;
        r_fl[0]  <= n_flag;
        r_dz[0]  <= n_dz;
        for (int k = 1; k < LAT; k++) begin
            r_v[k]   <= i_rst_n & r_v[k-1];
            r_op[k]  <= r_op[k-1];
            r_res[k] <= r_res[k-1];
            r_fl[k]  <= r_fl[k-1];
            r_dz[k]  <= r_dz[k-1];
        end
    end

    // The multiplier finishes two stages in, so its word joins the line there.
    logic [WW-1:0] r_mulq [LAT-2];
    always_ff @(posedge i_clk) begin
        r_mulq[0] <= mul_q;
        for (int k = 1; k < LAT-2; k++) begin
            r_mulq[k] <= r_mulq[k-1];
        end
    end

    always_comb begin
        o_valid = r_v[LAT-1];
        o_item.flag = r_fl[LAT-1];
        o_item.divide_by_zero = r_dz[LAT-1];
        case (r_op[LAT-1])
            OP_MUL:  o_item.result = r_mulq[LAT-3];
            OP_DIV:  o_item.result = r_dz[LAT-1] ? '0 : div_q;
            default: o_item.result = r_res[LAT-1];
        endcase
    end
endmodule

// File: rtl/fixed_point_alu_checker.sv
module fixed_point_alu_checker
    import fpa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_item,
    input logic o_valid,
    input t_out o_item
);
    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_no_out_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("beat straight after reset");
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_item.flag && o_item.divide_by_zero))
        else $error("flag and divide_by_zero together");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.divide_by_zero |-> o_item.result == '0)
        else $error("non-zero result on zero divisor");
endmodule

bind fixed_point_alu fixed_point_alu_checker u_chk (.*);
